[rtl/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// tfd_pkg
// types and constants of the tracker frame deframer
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] HdrStart = 8'd201;
  localparam logic [ByteW-1:0] HdrMid   = 8'd202;
  localparam logic [ByteW-1:0] HdrLate  = 8'd203;
  localparam logic [ByteW-1:0] YBias    = 8'd100;
  localparam logic [ByteW-1:0] YMaxByte = 8'd199;

  localparam logic [ByteW-1:0] BallMaxXRst = 8'd150;
  localparam logic [ByteW-1:0] GoalMaxXRst = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBallMaxX = 1'b0,
    CfgGoalMaxX = 1'b1
  } cfg_idx_e;

  typedef enum logic [PosW-1:0] {
    PosHunt   = 4'd0,
    PosBallX  = 4'd1,
    PosBallY  = 4'd2,
    PosMid    = 4'd3,
    PosYelX   = 4'd4,
    PosYelY   = 4'd5,
    PosLate   = 4'd6,
    PosBlueX  = 4'd7,
    PosBlueY  = 4'd8
  } pos_e;

  typedef logic [ByteW-1:0] link_t;

  typedef struct packed {
    logic              ball_updated;
    logic [ByteW-1:0]  ball_x;
    logic signed [7:0] ball_y;
    logic              yellow_updated;
    logic [ByteW-1:0]  yellow_x;
    logic signed [7:0] yellow_y;
    logic              blue_updated;
    logic [ByteW-1:0]  blue_x;
    logic signed [7:0] blue_y;
  } res_t;

  function automatic logic obj_ok(logic [ByteW-1:0] xb, logic [ByteW-1:0] yb,
                                  logic [ByteW-1:0] limit);
    obj_ok = (xb != '0) && (xb <= limit) && (yb != '0) && (yb <= YMaxByte);
  endfunction

  function automatic logic signed [7:0] y_of(logic [ByteW-1:0] yb);
    y_of = signed'(yb - YBias);
  endfunction

endpackage

[rtl/tfd_stream_if.sv]
// ----------------------------------------------------------------------------
// tfd_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface tfd_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/tracker_frame_deframer.sv]
// ----------------------------------------------------------------------------
// tracker_frame_deframer
// object position deframer for a camera byte link
// ----------------------------------------------------------------------------
// in_i carries one link byte per transaction. the block hunts for the 201
// header, then collects eight frame bytes with inner headers 202 and 203.
// a good frame gives one transaction on out_o with the update flags and
// the held last-good ball, yellow and blue positions; a bad frame gives none.
// one byte is taken every cycle that in_i.ready is high; the result of a
// frame appears on out_o from a single output register in the cycle after
// its last byte is accepted. in_i.ready drops only while the last byte of
// a frame is due and a previous result is still held in that register by
// a stalled receiver; all other bytes keep flowing during the stall.
// cfg_we_i/cfg_idx_i/cfg_data_i write the ball and goal x limits
// (index 0 and 1); write them only while the block is idle.
// reset returns to hunting, clears the held positions to zero, empties the
// output register and loads the limits with 150 and 200.
// ----------------------------------------------------------------------------
module tracker_frame_deframer
  import tfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  tfd_stream_if.sink         in_i,
  tfd_stream_if.source       out_o
);

  logic [ByteW-1:0] ball_max_q, goal_max_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             bad_q, bad_d;
  logic [ByteW-1:0] cap_q [5];
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  logic             in_acc, frame_end;
  link_t            b;

  assign b        = in_i.data;
  assign in_i.ready = !(out_valid_q && !out_o.ready && (pos_q == PosBlueY));
  assign in_acc   = in_i.valid && in_i.ready;
  assign frame_end = in_acc && (pos_q == PosBlueY) && !bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_max_q <= BallMaxXRst;
      goal_max_q <= GoalMaxXRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBallMaxX: ball_max_q <= cfg_data_i;
        CfgGoalMaxX: goal_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    bad_d = bad_q;
    if (in_acc) begin
      unique case (pos_e'(pos_q))
        PosHunt: begin
          if (b == HdrStart) begin
            pos_d = PosBallX;
            bad_d = 1'b0;
          end
        end
        PosMid: begin
          if (b != HdrMid) bad_d = 1'b1;
          pos_d = pos_q + 1'b1;
        end
        PosLate: begin
          if (b != HdrLate) bad_d = 1'b1;
          pos_d = pos_q + 1'b1;
        end
        PosBallX, PosBallY, PosYelX, PosYelY, PosBlueX: pos_d = pos_q + 1'b1;
        PosBlueY: pos_d = PosHunt;
        default: pos_d = PosHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      bad_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (pos_e'(pos_q))
        PosBallX: cap_q[0] <= b;
        PosBallY: cap_q[1] <= b;
        PosYelX:  cap_q[2] <= b;
        PosYelY:  cap_q[3] <= b;
        PosBlueX: cap_q[4] <= b;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (frame_end) begin
      out_valid_d          = 1'b1;
      res_d.ball_updated   = obj_ok(cap_q[0], cap_q[1], ball_max_q);
      res_d.yellow_updated = obj_ok(cap_q[2], cap_q[3], goal_max_q);
      res_d.blue_updated   = obj_ok(cap_q[4], b, goal_max_q);
      if (res_d.ball_updated) begin
        res_d.ball_x = cap_q[0];
        res_d.ball_y = y_of(cap_q[1]);
      end
      if (res_d.yellow_updated) begin
        res_d.yellow_x = cap_q[2];
        res_d.yellow_y = y_of(cap_q[3]);
      end
      if (res_d.blue_updated) begin
        res_d.blue_x = cap_q[4];
        res_d.blue_y = y_of(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosBlueY)
    else $error("frame position out of range");

  a_stall_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (pos_q == PosBlueY) && out_valid_q)
    else $error("input stalled away from the frame end");

  a_frame_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> out_valid_q)
    else $error("good frame gave no result");

  a_ball_x_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ball_updated |-> res_q.ball_x != '0)
    else $error("ball updated with zero distance");

  a_blue_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.blue_y > -8'sd100) && (res_q.blue_y < 8'sd100))
    else $error("blue lateral offset out of range");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench of the tracker frame deframer
// ----------------------------------------------------------------------------
// drives link bytes into in_i and predicts every frame result from its own
// model of the hunt, capture and acceptance rules. each out_o transaction is
// checked field by field against the oldest predicted frame. a directed part
// covers field extremes, a bad middle header and a header byte inside a frame.
// limit extremes follow, then random frame traffic under three idle patterns
// on both sides. limits are rewritten only when nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top
  import tfd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseBytes = 320;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  cfg_idx_e   cfg_idx;
  link_t      cfg_data;

  tfd_stream_if #(.T(link_t)) in_if ();
  tfd_stream_if #(.T(res_t))  out_if ();

  tracker_frame_deframer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // frame predictor state
  pos_e              frame_pos;
  bit                frame_bad;
  link_t             frame_byte [9];
  link_t             ball_lim;
  link_t             goal_lim;
  link_t             held_ball_x, held_yel_x, held_blue_x;
  logic signed [7:0] held_ball_y, held_yel_y, held_blue_y;
  res_t              frame_results_q [$];

  int unsigned bytes_sent;
  int unsigned n_errors;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned cycle_cnt;

  function automatic bit take_object(input link_t xb, input link_t yb, input link_t lim,
                                     inout link_t hx, inout logic signed [7:0] hy);
    int yv;
    yv = int'(yb) - 100;
    if (xb != 8'd0 && xb <= lim && yv > -100 && yv < 100) begin
      hx = xb;
      hy = yv[7:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_byte(input link_t b);
    res_t r;
    if (frame_pos == PosHunt) begin
      if (b == HdrStart) begin
        frame_pos = PosBallX;
        frame_bad = 1'b0;
      end
      return;
    end
    frame_byte[frame_pos] = b;
    if ((frame_pos == PosMid && b != HdrMid) || (frame_pos == PosLate && b != HdrLate))
      frame_bad = 1'b1;
    if (frame_pos != PosBlueY) begin
      frame_pos = pos_e'(frame_pos + 4'd1);
      return;
    end
    frame_pos = PosHunt;
    if (frame_bad) return;
    r.ball_updated   = take_object(frame_byte[PosBallX], frame_byte[PosBallY], ball_lim,
                                   held_ball_x, held_ball_y);
    r.yellow_updated = take_object(frame_byte[PosYelX], frame_byte[PosYelY], goal_lim,
                                   held_yel_x, held_yel_y);
    r.blue_updated   = take_object(frame_byte[PosBlueX], frame_byte[PosBlueY], goal_lim,
                                   held_blue_x, held_blue_y);
    r.ball_x   = held_ball_x;
    r.ball_y   = held_ball_y;
    r.yellow_x = held_yel_x;
    r.yellow_y = held_yel_y;
    r.blue_x   = held_blue_x;
    r.blue_y   = held_blue_y;
    frame_results_q.push_back(r);
  endtask

  // entered and left just after a falling edge
  task automatic send_byte(input link_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // completes any open frame, then waits for every result and for the block to settle
  task automatic drain_traffic();
    while (frame_pos != PosHunt) send_byte(8'd0);
    in_if.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_limits(input link_t ball, input link_t goal);
    drain_traffic();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBallMaxX;
    cfg_data <= ball;
    ball_lim  = ball;
    @(negedge clk_i);
    cfg_idx  <= CfgGoalMaxX;
    cfg_data <= goal;
    goal_lim  = goal;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic link_t pick_x(input link_t lim);
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return lim;
      3: return lim + 8'd1;
      default: return link_t'($urandom_range(255));
    endcase
  endfunction

  function automatic link_t pick_y();
    link_t edges [8] = '{8'd0, 8'd1, 8'd99, 8'd100, 8'd101, 8'd199, 8'd200, 8'd255};
    case ($urandom_range(4))
      0: return link_t'($urandom_range(255));
      1: return edges[$urandom_range(7)];
      default: return link_t'($urandom_range(1, 199));
    endcase
  endfunction

  function automatic link_t wrong_header(input link_t good);
    link_t v;
    v = link_t'($urandom_range(255));
    if (v == good) v = v ^ 8'h01;
    return v;
  endfunction

  task automatic send_frame(input bit broken);
    link_t mid, late;
    bit    which;
    which = $urandom_range(1);
    mid   = (broken && which)  ? wrong_header(HdrMid)  : HdrMid;
    late  = (broken && !which) ? wrong_header(HdrLate) : HdrLate;
    if (broken && $urandom_range(3) == 0) begin
      mid  = wrong_header(HdrMid);
      late = wrong_header(HdrLate);
    end
    send_byte(HdrStart);
    send_byte(pick_x(ball_lim));
    send_byte(pick_y());
    send_byte(mid);
    send_byte(pick_x(goal_lim));
    send_byte(pick_y());
    send_byte(late);
    send_byte(pick_x(goal_lim));
    send_byte(pick_y());
  endtask

  task automatic test_directed_frames();
    link_t seq [29] = '{
      8'd0, 8'd255,
      // ball at its limit, yellow at the low edges, blue over its limit
      8'd201, 8'd150, 8'd199, 8'd202, 8'd1, 8'd1, 8'd203, 8'd201, 8'd100,
      // wrong middle header, dropped whole
      8'd201, 8'd151, 8'd0, 8'd203, 8'd200, 8'd200, 8'd203, 8'd255, 8'd255,
      // every object rejected, held positions kept
      8'd201, 8'd151, 8'd100, 8'd202, 8'd200, 8'd0, 8'd203, 8'd0, 8'd50
    };
    src_idle_pct = 12;
    snk_idle_pct = 59;
    foreach (seq[i]) send_byte(seq[i]);
    drain_traffic();
  endtask

  task automatic test_limit_extremes();
    write_limits(8'd0, 8'd255);
    repeat (4) send_frame(1'b0);
    write_limits(8'd255, 8'd0);
    repeat (4) send_frame(1'b0);
    drain_traffic();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input link_t ball, input link_t goal);
    int unsigned stop_at;
    write_limits(ball, goal);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = bytes_sent + PhaseBytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) send_byte(link_t'($urandom_range(255)));
      send_frame($urandom_range(9) == 0);
    end
    drain_traffic();
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result transaction with no frame expected");
        n_errors++;
      end else begin
        e = frame_results_q.pop_front();
        check_field("ball_updated", e.ball_updated, out_if.data.ball_updated);
        check_field("ball_x", e.ball_x, out_if.data.ball_x);
        check_field("ball_y", e.ball_y, out_if.data.ball_y);
        check_field("yellow_updated", e.yellow_updated, out_if.data.yellow_updated);
        check_field("yellow_x", e.yellow_x, out_if.data.yellow_x);
        check_field("yellow_y", e.yellow_y, out_if.data.yellow_y);
        check_field("blue_updated", e.blue_updated, out_if.data.blue_updated);
        check_field("blue_x", e.blue_x, out_if.data.blue_x);
        check_field("blue_y", e.blue_y, out_if.data.blue_y);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgBallMaxX;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    bytes_sent   = 0;
    n_errors     = 0;
    frame_pos    = PosHunt;
    frame_bad    = 1'b0;
    ball_lim     = BallMaxXRst;
    goal_lim     = GoalMaxXRst;
    held_ball_x  = '0;
    held_ball_y  = '0;
    held_yel_x   = '0;
    held_yel_y   = '0;
    held_blue_x  = '0;
    held_blue_y  = '0;
    foreach (frame_byte[i]) frame_byte[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_limit_extremes();
    test_random_traffic(12, 59, link_t'($urandom_range(1, 255)),
                        link_t'($urandom_range(1, 255)));
    test_random_traffic(59, 12, link_t'($urandom_range(1, 255)),
                        link_t'($urandom_range(1, 255)));
    test_random_traffic(0, 0, BallMaxXRst, GoalMaxXRst);

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
